// ===== src/rma_pkg.sv =====
package rma_pkg;

    // Fixed widths of the result fields
    localparam int MEAN_BITS = 20;
    localparam int FILL_BITS = 7;

    typedef logic [MEAN_BITS-1:0] mean_t;
    typedef logic [FILL_BITS-1:0] fill_t;

endpackage

// ===== src/rma_if.sv =====
interface rma_sample_if #(
    parameter int SAMPLE_BITS = 20
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample_value;

    modport source (output valid, output sample_value, input ready);
    modport sink   (input valid, input sample_value, output ready);
endinterface

interface rma_mean_if;
    logic           valid;
    logic           ready;
    rma_pkg::mean_t mean_value;
    rma_pkg::fill_t fill_count;

    modport source (output valid, output mean_value, output fill_count, input ready);
    modport sink   (input valid, input mean_value, input fill_count, output ready);
endinterface

// ===== src/rma_cell.sv =====
module rma_cell #(
    parameter int SAMPLE_BITS = 20
) (
    input  logic                   clk,
    input  logic                   shift,
    input  logic [SAMPLE_BITS-1:0] d,
    output logic [SAMPLE_BITS-1:0] q
);

    logic [SAMPLE_BITS-1:0] data_reg;

    // Payload only: an unwritten cell is never used before it is filled
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            data_reg <= d;
        end
    end

    assign q = data_reg;

endmodule

// ===== src/rma_divider.sv =====
module rma_divider #(
    parameter int SUM_BITS = 27,
    parameter int CNT_BITS = 7
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [SUM_BITS-1:0] dividend,
    input  logic [CNT_BITS-1:0] divisor,
    output logic                done,
    output logic [SUM_BITS-1:0] quotient
);

    localparam int ITER_BITS = $clog2(SUM_BITS + 1);

    logic                 busy_reg,  busy_next;
    logic                 done_reg,  done_next;
    logic [ITER_BITS-1:0] count_reg, count_next;
    logic [CNT_BITS-1:0]  rem_reg,   rem_next;
    logic [SUM_BITS-1:0]  quot_reg,  quot_next;
    logic [CNT_BITS-1:0]  dvsr_reg,  dvsr_next;
    logic [CNT_BITS:0]    trial;
    logic                 fits;

    // One quotient bit per cycle, dividend bits shift out at the top
    assign trial = {rem_reg, quot_reg[SUM_BITS-1]};
    assign fits  = (trial >= {1'b0, dvsr_reg});

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        rem_next   = rem_reg;
        quot_next  = quot_reg;
        dvsr_next  = dvsr_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = ITER_BITS'(SUM_BITS);
            rem_next   = '0;
            quot_next  = dividend;
            dvsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = CNT_BITS'(trial - {1'b0, dvsr_reg});
            end
            else
            begin
                rem_next = CNT_BITS'(trial);
            end
            quot_next  = {quot_reg[SUM_BITS-2:0], fits};
            count_next = count_reg - ITER_BITS'(1);
            if (count_reg == ITER_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        dvsr_reg <= dvsr_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

// ===== src/rolling_mean_with_warmup_unit.sv =====
// Boxcar moving average over the last WINDOW unsigned samples. Each sample
// shifts into a row of WINDOW cells; the running sum adds the new sample and
// drops the one leaving the far end of the row once the row is full. Every
// sample gives one result: the sum divided by the number of samples held
// (1..WINDOW), truncated toward zero, with that count. The divide is a
// restoring divider that produces one quotient bit per cycle over the
// SAMPLE_BITS + clog2(WINDOW) bits of the sum. A new sample is accepted
// only once the divide has finished and its result has been loaded into
// the output register. The result sits in an output register, so a
// waiting result does not block the next sample.
module rolling_mean_with_warmup_unit #(
    parameter int WINDOW      = 120,
    parameter int SAMPLE_BITS = 20
) (
    input  logic              clk,
    input  logic              rst_n,
    rma_sample_if.sink        samples,
    rma_mean_if.source        means
);

    localparam int CNT_BITS = $clog2(WINDOW + 1);
    localparam int SUM_BITS = SAMPLE_BITS + $clog2(WINDOW);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [SUM_BITS-1:0]   sum_reg,   sum_next;
    logic [CNT_BITS-1:0]   fill_reg,  fill_next;
    logic                  out_valid_reg, out_valid_next;
    rma_pkg::mean_t        mean_reg;
    rma_pkg::fill_t        fill_out_reg;

    logic                  accept;
    logic                  row_full;
    logic                  load;
    logic                  div_done;
    logic [SUM_BITS-1:0]   quotient;
    logic [SAMPLE_BITS-1:0] oldest;
    logic [SAMPLE_BITS-1:0] chain [WINDOW+1];

    assign accept   = samples.valid && samples.ready;
    assign row_full = (fill_reg == CNT_BITS'(WINDOW));

    // Row of sample cells; chain[0] is the incoming sample
    assign chain[0] = samples.sample_value;

    for (genvar i = 0; i < WINDOW; i++)
    begin : g_cell
        rma_cell #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_cell (
            .clk   (clk),
            .shift (accept),
            .d     (chain[i]),
            .q     (chain[i+1])
        );
    end

    // The far cell counts only once the row has been filled
    assign oldest = row_full ? chain[WINDOW] : '0;

    always_comb
    begin
        sum_next  = sum_reg;
        fill_next = fill_reg;
        if (accept)
        begin
            sum_next = sum_reg + SUM_BITS'(samples.sample_value) - SUM_BITS'(oldest);
            if (!row_full)
            begin
                fill_next = fill_reg + CNT_BITS'(1);
            end
        end
    end

    rma_divider #(
        .SUM_BITS (SUM_BITS),
        .CNT_BITS (CNT_BITS)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .dividend (sum_next),
        .divisor  (fill_next),
        .done     (div_done),
        .quotient (quotient)
    );

    assign load = (((state_reg == ST_DIV) && div_done) || (state_reg == ST_HOLD))
                  && (!out_valid_reg || means.ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = load ? ST_IDLE : ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (means.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sum_reg       <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mean_reg     <= rma_pkg::MEAN_BITS'(quotient);
            fill_out_reg <= rma_pkg::FILL_BITS'(fill_reg);
        end
    end

    assign samples.ready    = (state_reg == ST_IDLE);
    assign means.valid      = out_valid_reg;
    assign means.mean_value = mean_reg;
    assign means.fill_count = fill_out_reg;

endmodule
